FILE: rtl/core/apio_pkg.sv
// ----------------------------------------------------------------------------
// ATA PIO task file package
// Shared types and constants for the LBA28 PIO device with RAM disk.
// ----------------------------------------------------------------------------
package apio_pkg;

  localparam int ApioWordsPerSector = 256;
  localparam int ApioDiskSectorsDef = 64;
  localparam int ApioAddrMaxW       = 24;
  localparam int ApioQueueDepth     = 2;

  localparam logic [7:0] CmdRead  = 8'h20;
  localparam logic [7:0] CmdWrite = 8'h30;
  localparam logic [7:0] CmdFlush = 8'hE7;

  localparam logic [7:0] StDrdy  = 8'h40;
  localparam logic [7:0] StDrq   = 8'h08;
  localparam logic [7:0] StErr   = 8'h01;
  localparam logic [7:0] ErIdnf  = 8'h10;
  localparam logic [7:0] ErAbrt  = 8'h04;
  localparam logic [7:0] DriveHeadRst = 8'hE0;

  typedef enum logic [2:0] {
    REG_DATA   = 3'd0,
    REG_FEAT   = 3'd1,
    REG_COUNT  = 3'd2,
    REG_LBA_LO = 3'd3,
    REG_LBA_MD = 3'd4,
    REG_LBA_HI = 3'd5,
    REG_DRIVE  = 3'd6,
    REG_CMD    = 3'd7
  } apio_reg_e;

  typedef enum logic [1:0] {
    OP_CONST = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } apio_op_e;

  typedef struct packed {
    apio_op_e                  op;
    logic [ApioAddrMaxW-1:0]   addr;
    logic [15:0]               data;
  } apio_entry_t;

endpackage

FILE: rtl/core/apio_front.sv
// ----------------------------------------------------------------------------
// ATA PIO front end
// Takes bus accesses, keeps the task file and transfer state, and emits one
// store operation or constant result per item.
// ----------------------------------------------------------------------------
module apio_front import apio_pkg::*; #(
  parameter int DISK_SECTORS = ApioDiskSectorsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        is_write_i,
  input  logic [2:0]  reg_offset_i,
  input  logic [15:0] write_data_i,
  input  logic        clr_busy_i,
  input  logic        q_ready_i,
  output logic        push_o,
  output apio_entry_t push_entry_o
);

  localparam int SecW = (DISK_SECTORS > 1) ? $clog2(DISK_SECTORS) : 1;
  localparam logic [28:0] DiskLimit = 29'(DISK_SECTORS);

  logic        drive_unit_q;
  logic [7:0]  feat_q, feat_d, count_q, count_d;
  logic [7:0]  lba_lo_q, lba_lo_d, lba_md_q, lba_md_d, lba_hi_q, lba_hi_d;
  logic [7:0]  drive_q, drive_d, error_q, error_d;
  logic        err_q, err_d, drq_q, drq_d, wdir_q, wdir_d;
  logic [27:0] cur_lba_q, cur_lba_d;
  logic [8:0]  left_q, left_d;
  logic [7:0]  word_q, word_d;

  logic        accept, sel, port_ok;
  logic [7:0]  wbyte, status;
  logic [27:0] cmd_lba;
  logic [8:0]  cmd_cnt;
  logic [28:0] cmd_end;
  apio_reg_e   off;

  assign in_ready_o = q_ready_i && !clr_busy_i;
  assign accept     = in_valid_i && in_ready_o;
  assign off        = apio_reg_e'(reg_offset_i);
  assign wbyte      = write_data_i[7:0];
  assign sel        = (drive_q[4] == drive_unit_q);
  assign port_ok    = sel && drq_q && (wdir_q == is_write_i);
  assign cmd_lba    = {drive_q[3:0], lba_hi_q, lba_md_q, lba_lo_q};
  assign cmd_cnt    = (count_q == 8'h00) ? 9'd256 : {1'b0, count_q};
  assign cmd_end    = {1'b0, cmd_lba} + {20'd0, cmd_cnt};
  assign status     = StDrdy | (drq_q ? StDrq : 8'h00) | (err_q ? StErr : 8'h00);

  always_comb begin
    feat_d    = feat_q;
    count_d   = count_q;
    lba_lo_d  = lba_lo_q;
    lba_md_d  = lba_md_q;
    lba_hi_d  = lba_hi_q;
    drive_d   = drive_q;
    error_d   = error_q;
    err_d     = err_q;
    drq_d     = drq_q;
    wdir_d    = wdir_q;
    cur_lba_d = cur_lba_q;
    left_d    = left_q;
    word_d    = word_q;
    push_entry_o = '{op: OP_CONST, addr: '0, data: '0};

    if (accept) begin
      if (off == REG_DATA) begin
        if (port_ok) begin
          if (cur_lba_q >= 28'(DISK_SECTORS)) begin
            drq_d = 1'b0;
          end else begin
            push_entry_o.op   = is_write_i ? OP_WRITE : OP_READ;
            push_entry_o.addr = ApioAddrMaxW'({cur_lba_q[SecW-1:0], word_q});
            push_entry_o.data = write_data_i;
            word_d = word_q + 8'd1;
            if (word_q == 8'hFF) begin
              cur_lba_d = cur_lba_q + 28'd1;
              left_d    = left_q - 9'd1;
              if (left_q == 9'd1) begin
                drq_d = 1'b0;
              end
            end
          end
        end
      end else if (is_write_i) begin
        case (off)
          REG_FEAT:   feat_d   = wbyte;
          REG_COUNT:  count_d  = wbyte;
          REG_LBA_LO: lba_lo_d = wbyte;
          REG_LBA_MD: lba_md_d = wbyte;
          REG_LBA_HI: lba_hi_d = wbyte;
          REG_DRIVE:  drive_d  = wbyte;
          REG_CMD: begin
            if (sel) begin
              err_d   = 1'b0;
              error_d = 8'h00;
              drq_d   = 1'b0;
              if (wbyte == CmdRead || wbyte == CmdWrite) begin
                if (cmd_end > DiskLimit) begin
                  err_d   = 1'b1;
                  error_d = ErIdnf;
                end else begin
                  cur_lba_d = cmd_lba;
                  left_d    = cmd_cnt;
                  word_d    = 8'h00;
                  wdir_d    = (wbyte == CmdWrite);
                  drq_d     = 1'b1;
                end
              end else if (wbyte != CmdFlush) begin
                err_d   = 1'b1;
                error_d = ErAbrt;
              end
            end
          end
          default: ;
        endcase
      end else if (sel) begin
        case (off)
          REG_FEAT:   push_entry_o.data = {8'h00, error_q};
          REG_COUNT:  push_entry_o.data = {8'h00, count_q};
          REG_LBA_LO: push_entry_o.data = {8'h00, lba_lo_q};
          REG_LBA_MD: push_entry_o.data = {8'h00, lba_md_q};
          REG_LBA_HI: push_entry_o.data = {8'h00, lba_hi_q};
          REG_DRIVE:  push_entry_o.data = {8'h00, drive_q};
          REG_CMD:    push_entry_o.data = {8'h00, status};
          default:    push_entry_o.data = 16'h0000;
        endcase
      end
    end
  end

  assign push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_unit_q <= 1'b0;
      feat_q       <= 8'h00;
      count_q      <= 8'h00;
      lba_lo_q     <= 8'h00;
      lba_md_q     <= 8'h00;
      lba_hi_q     <= 8'h00;
      drive_q      <= DriveHeadRst;
      error_q      <= 8'h00;
      err_q        <= 1'b0;
      drq_q        <= 1'b0;
      wdir_q       <= 1'b0;
      cur_lba_q    <= '0;
      left_q       <= '0;
      word_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        drive_unit_q <= cfg_data_i;
      end
      feat_q    <= feat_d;
      count_q   <= count_d;
      lba_lo_q  <= lba_lo_d;
      lba_md_q  <= lba_md_d;
      lba_hi_q  <= lba_hi_d;
      drive_q   <= drive_d;
      error_q   <= error_d;
      err_q     <= err_d;
      drq_q     <= drq_d;
      wdir_q    <= wdir_d;
      cur_lba_q <= cur_lba_d;
      left_q    <= left_d;
      word_q    <= word_d;
    end
  end

  // features register is write-only from the host side
  logic feat_unused;
  assign feat_unused = ^feat_q;

endmodule

FILE: rtl/core/apio_queue.sv
// ----------------------------------------------------------------------------
// ATA PIO operation queue
// Short FIFO between the front end and the store back end.
// ----------------------------------------------------------------------------
module apio_queue import apio_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  apio_entry_t push_entry_i,
  output logic        ready_o,
  output logic        valid_o,
  output apio_entry_t entry_o,
  input  logic        pop_i
);

  localparam int PtrW = $clog2(ApioQueueDepth);
  localparam int CntW = $clog2(ApioQueueDepth + 1);

  apio_entry_t         slot_q [ApioQueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(ApioQueueDepth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = slot_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(ApioQueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(ApioQueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/apio_back.sv
// ----------------------------------------------------------------------------
// ATA PIO back end
// Sector store RAM with clearing pass, and the registered result stage.
// ----------------------------------------------------------------------------
module apio_back import apio_pkg::*; #(
  parameter int DISK_SECTORS = ApioDiskSectorsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  apio_entry_t q_entry_i,
  output logic        q_pop_o,
  output logic        clr_busy_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_data_o
);

  localparam int Depth = DISK_SECTORS * ApioWordsPerSector;
  localparam int AW    = $clog2(Depth);

  logic [15:0]   mem_q [Depth];
  logic [15:0]   rdata_q, const_q;
  logic          out_valid_q, from_mem_q;
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  logic          pop, mem_we, mem_re;
  logic [AW-1:0] mem_waddr, op_addr;
  logic [15:0]   mem_wdata;

  assign pop     = q_valid_i && !clr_busy_q && (!out_valid_q || out_ready_i);
  assign q_pop_o = pop;
  assign op_addr = q_entry_i.addr[AW-1:0];

  assign mem_we    = clr_busy_q || (pop && q_entry_i.op == OP_WRITE);
  assign mem_waddr = clr_busy_q ? clr_addr_q : op_addr;
  assign mem_wdata = clr_busy_q ? 16'h0000 : q_entry_i.data;
  assign mem_re    = pop && (q_entry_i.op == OP_READ);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[op_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      const_q <= (q_entry_i.op == OP_CONST) ? q_entry_i.data : 16'h0000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      from_mem_q  <= 1'b0;
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
    end else begin
      if (pop) begin
        out_valid_q <= 1'b1;
        from_mem_q  <= (q_entry_i.op == OP_READ);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (clr_busy_q) begin
        if (clr_addr_q == AW'(Depth - 1)) begin
          clr_busy_q <= 1'b0;
        end else begin
          clr_addr_q <= clr_addr_q + 1'b1;
        end
      end
    end
  end

  assign clr_busy_o  = clr_busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = from_mem_q ? rdata_q : const_q;

endmodule

FILE: rtl/core/ata_pio_lba28_device.sv
// ----------------------------------------------------------------------------
// ATA PIO LBA28 device
// Path: an accepted item is held in the queue, then in the result register.
// Throughput: one item per cycle while m_axis_tready is high; one sector
// store word per data access. Reset: task file to power-on values; the
// store is zeroed by a clearing pass, during which s_axis_tready stays low.
// ----------------------------------------------------------------------------
module ata_pio_lba28_device import apio_pkg::*; #(
  parameter int DISK_SECTORS = ApioDiskSectorsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,     // drive_unit
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // write_data
  input  logic [3:0]  s_axis_tuser,   // reg_offset[2:0], is_write
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // read_data
);

  logic        push, q_ready, q_valid, q_pop, clr_busy;
  apio_entry_t push_entry, q_entry;

  assign cfg_ready_o = 1'b1;

  apio_front #(
    .DISK_SECTORS(DISK_SECTORS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .is_write_i   (s_axis_tuser[0]),
    .reg_offset_i (s_axis_tuser[3:1]),
    .write_data_i (s_axis_tdata),
    .clr_busy_i   (clr_busy),
    .q_ready_i    (q_ready),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  apio_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .ready_o      (q_ready),
    .valid_o      (q_valid),
    .entry_o      (q_entry),
    .pop_i        (q_pop)
  );

  apio_back #(
    .DISK_SECTORS(DISK_SECTORS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .clr_busy_o  (clr_busy),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
